// ===== sv/ffba_pkg.sv =====
// Shared types and constants for the first-fit block allocator.
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int unsigned POOL_SIZE_DEF = 256;
  localparam int unsigned ADDR_W        = 9;
  localparam int unsigned SIZE_W        = 9;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_ADDR = 2'd2,
    ST_BAD_SIZE = 2'd3
  } status_e;

  // One pool unit: busy flag and block-start mark.
  typedef struct packed {
    logic busy;
    logic blk_start;
  } unit_t;

endpackage

// ===== sv/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator: ring of unit cells plus sequencer.
`timescale 1ns / 1ps

// First-fit allocator over POOL_SIZE units. Each unit sits in a cell of a
// circular chain that rotates by one unit per cycle during a request, so the
// sequencer sees every unit at the chain head in address order and writes it
// back at the tail. One request is in flight at a time. An allocate that finds
// room makes one rotation to find the first free run that fits and a second
// to mark it, then loads the output register; an allocate that finds no room
// and a free make one rotation and then load it; a request rejected for size
// or address range loads it with no rotation. The next request is accepted
// from the cycle after the result is loaded, even if that result has not yet
// been taken; a result still waiting when the next one is ready holds the
// sequencer until it is taken. The pool is all free right after reset; no
// clearing pass is needed.

module first_fit_block_allocator #(
  parameter int unsigned POOL_SIZE = ffba_pkg::POOL_SIZE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [8:0] request_size, [17:9] block_address
  input  logic        s_axis_tuser,  // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [8:0] result_address
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  ffba_pkg::unit_t cell_q [POOL_SIZE];
  ffba_pkg::unit_t tail;
  logic            shift;
  logic [ffba_pkg::ADDR_W-1:0] res_addr;

  for (genvar i = 0; i < POOL_SIZE; i++) begin : g_ring
    if (i == POOL_SIZE - 1) begin : g_tail
      ffba_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .unit_i  (tail),
        .unit_o  (cell_q[i])
      );
    end else begin : g_body
      ffba_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .unit_i  (cell_q[i+1]),
        .unit_o  (cell_q[i])
      );
    end
  end

  ffba_ctrl #(
    .POOL_SIZE (POOL_SIZE)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (s_axis_tvalid),
    .req_ready_o      (s_axis_tready),
    .action_i         (s_axis_tuser),
    .request_size_i   (s_axis_tdata[8:0]),
    .block_address_i  (s_axis_tdata[17:9]),
    .rsp_valid_o      (m_axis_tvalid),
    .rsp_ready_i      (m_axis_tready),
    .result_address_o (res_addr),
    .status_o         (m_axis_tuser),
    .head_i           (cell_q[0]),
    .tail_o           (tail),
    .shift_o          (shift)
  );

  assign m_axis_tdata = {7'd0, res_addr};

endmodule

// ===== sv/ffba_cell.sv =====
// One unit of the rotating pool ring.
`timescale 1ns / 1ps

module ffba_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  ffba_pkg::unit_t unit_i,
  output ffba_pkg::unit_t unit_o
);

  ffba_pkg::unit_t unit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= '0;
    end else if (shift_i) begin
      unit_q <= unit_i;
    end
  end

  assign unit_o = unit_q;

endmodule

// ===== sv/ffba_ctrl.sv =====
// Request sequencer: scans the ring head, rewrites units, holds the result.
`timescale 1ns / 1ps

module ffba_ctrl #(
  parameter int unsigned POOL_SIZE = ffba_pkg::POOL_SIZE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  logic                          action_i,
  input  logic [ffba_pkg::SIZE_W-1:0]   request_size_i,
  input  logic [ffba_pkg::ADDR_W-1:0]   block_address_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic [ffba_pkg::ADDR_W-1:0]   result_address_o,
  output logic [1:0]                    status_o,
  input  ffba_pkg::unit_t               head_i,
  output ffba_pkg::unit_t               tail_o,
  output logic                          shift_o
);

  localparam int unsigned CW = $clog2(POOL_SIZE);
  localparam int unsigned W  = (CW + 1 > ffba_pkg::ADDR_W) ? CW + 1 : ffba_pkg::ADDR_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FIND = 5'b00010,
    S_MARK = 5'b00100,
    S_FREE = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW:0]   run_q, run_d;
  logic [CW:0]   end_q, end_d;
  logic [CW-1:0] start_q, start_d;
  logic          found_q, found_d;
  logic          bad_q, bad_d;
  logic          clr_q, clr_d;
  logic [ffba_pkg::SIZE_W-1:0] size_q, size_d;
  logic [ffba_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic [ffba_pkg::ADDR_W-1:0] res_addr_q, res_addr_d;
  ffba_pkg::status_e           res_st_q, res_st_d;
  logic                        m_valid_q, m_valid_d;
  logic [ffba_pkg::ADDR_W-1:0] m_addr_q, m_addr_d;
  ffba_pkg::status_e           m_st_q, m_st_d;

  logic          accept;
  logic          last;
  logic [CW:0]   run_inc;
  logic [W-1:0]  fit_start;
  logic          in_range;
  logic [ffba_pkg::ADDR_W-1:0] pool_addr;

  assign accept    = req_valid_i && req_ready_o;
  assign req_ready_o = (state_q == S_IDLE);
  assign last      = (cnt_q == CW'(POOL_SIZE - 1));
  assign run_inc   = run_q + 1'b1;
  assign fit_start = W'(cnt_q) + W'(1) - W'(size_q);
  assign in_range  = (cnt_q >= start_q) && ((CW + 1)'(cnt_q) < end_q);
  assign pool_addr = ffba_pkg::ADDR_W'(W'(POOL_SIZE));

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    run_d      = run_q;
    end_d      = end_q;
    start_d    = start_q;
    found_d    = found_q;
    bad_d      = bad_q;
    clr_d      = clr_q;
    size_d     = size_q;
    addr_d     = addr_q;
    res_addr_d = res_addr_q;
    res_st_d   = res_st_q;
    m_valid_d  = m_valid_q && !rsp_ready_i;
    m_addr_d   = m_addr_q;
    m_st_d     = m_st_q;
    shift_o    = 1'b0;
    tail_o     = head_i;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          size_d  = request_size_i;
          addr_d  = block_address_i;
          cnt_d   = '0;
          run_d   = '0;
          found_d = 1'b0;
          bad_d   = 1'b0;
          clr_d   = 1'b0;
          res_addr_d = pool_addr;
          if (action_i == ffba_pkg::ACT_ALLOC) begin
            if (request_size_i == '0) begin
              res_st_d = ffba_pkg::ST_BAD_SIZE;
              state_d  = S_DONE;
            end else if (W'(request_size_i) > W'(POOL_SIZE)) begin
              res_st_d = ffba_pkg::ST_NO_SPACE;
              state_d  = S_DONE;
            end else begin
              state_d = S_FIND;
            end
          end else begin
            if (W'(block_address_i) >= W'(POOL_SIZE)) begin
              res_st_d = ffba_pkg::ST_BAD_ADDR;
              state_d  = S_DONE;
            end else begin
              state_d = S_FREE;
            end
          end
        end
      end
      S_FIND: begin
        shift_o = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        run_d   = head_i.busy ? '0 : run_inc;
        if (!found_q && !head_i.busy && (W'(run_inc) == W'(size_q))) begin
          found_d = 1'b1;
          end_d   = (CW + 1)'(cnt_q) + 1'b1;
          start_d = CW'(fit_start);
        end
        if (last) begin
          cnt_d = '0;
          if (found_d) begin
            state_d = S_MARK;
          end else begin
            res_addr_d = pool_addr;
            res_st_d   = ffba_pkg::ST_NO_SPACE;
            state_d    = S_DONE;
          end
        end
      end
      S_MARK: begin
        shift_o = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        if (in_range) begin
          tail_o.busy      = 1'b1;
          tail_o.blk_start = (cnt_q == start_q);
        end
        if (last) begin
          cnt_d      = '0;
          res_addr_d = ffba_pkg::ADDR_W'(W'(start_q));
          res_st_d   = ffba_pkg::ST_OK;
          state_d    = S_DONE;
        end
      end
      S_FREE: begin
        shift_o = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        if (W'(cnt_q) == W'(addr_q)) begin
          if (head_i.blk_start) begin
            tail_o = '0;
            clr_d  = 1'b1;
          end else begin
            bad_d = 1'b1;
          end
        end else if (clr_q) begin
          if (head_i.busy && !head_i.blk_start) begin
            tail_o = '0;
          end else begin
            clr_d = 1'b0;
          end
        end
        if (last) begin
          cnt_d = '0;
          if (bad_d) begin
            res_addr_d = pool_addr;
            res_st_d   = ffba_pkg::ST_BAD_ADDR;
          end else begin
            res_addr_d = addr_q;
            res_st_d   = ffba_pkg::ST_OK;
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_valid_q || rsp_ready_i) begin
          m_valid_d = 1'b1;
          m_addr_d  = res_addr_q;
          m_st_d    = res_st_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      run_q     <= '0;
      found_q   <= 1'b0;
      bad_q     <= 1'b0;
      clr_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      run_q     <= run_d;
      found_q   <= found_d;
      bad_q     <= bad_d;
      clr_q     <= clr_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q      <= end_d;
    start_q    <= start_d;
    size_q     <= size_d;
    addr_q     <= addr_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    m_addr_q   <= m_addr_d;
    m_st_q     <= m_st_d;
  end

  assign rsp_valid_o      = m_valid_q;
  assign result_address_o = m_addr_q;
  assign status_o         = m_st_q;

  // Ring only moves while a pass is running.
  a_shift_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_o |-> (state_q == S_FIND || state_q == S_MARK || state_q == S_FREE))
    else $error("ring shifted outside a scan pass");

  // Allocation only claims units that were free.
  a_mark_free_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MARK && in_range) |-> !head_i.busy)
    else $error("allocation overlaps a busy unit");

  // First unit of the new block carries the start mark.
  a_mark_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MARK && cnt_q == start_q) |-> (tail_o.busy && tail_o.blk_start))
    else $error("block start not marked");

  // Release never sets a unit busy.
  a_free_no_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FREE && tail_o.busy) |-> head_i.busy)
    else $error("release set a unit busy");

  // A pass always runs a full rotation from unit zero.
  a_pass_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && state_d != S_IDLE) |=> (cnt_q == '0))
    else $error("pass did not start at unit zero");

endmodule
